// ===== rtl/core/avls_pkg.sv =====
// shared types, constants and helpers for the lip-sync delay steering block
package avls_pkg;

    localparam int unsigned MS_W      = 12;
    localparam int unsigned OFFSET_W  = 13;
    localparam int unsigned STEP_W    = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 13;
    localparam int unsigned WIDE_W    = 16;

    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_wide AUDIO_FLOOR_MS = 16'sd40;
    localparam t_wide MS_MAX         = 16'sd4095;

    localparam logic [STEP_W-1:0] VIDEO_STEP_RST = 10'd80;
    localparam logic [STEP_W-1:0] AUDIO_STEP_RST = 10'd80;
    localparam logic [MS_W-1:0]   MAX_TOTAL_RST  = 12'd1500;

    // steering direction, two's complement -1 / 0 / +1
    localparam logic signed [1:0] DIR_VIDEO = 2'sb11;
    localparam logic signed [1:0] DIR_NONE  = 2'sb00;
    localparam logic signed [1:0] DIR_AUDIO = 2'sb01;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_ENABLE    = 3'd0,
        CFG_NETWORK_OFFSET = 3'd1,
        CFG_MAX_VIDEO_STEP = 3'd2,
        CFG_MAX_AUDIO_STEP = 3'd3,
        CFG_MAX_TOTAL      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                       sync_enable;
        logic signed [OFFSET_W-1:0] network_offset_ms;
        logic [STEP_W-1:0]          max_video_step_ms;
        logic [STEP_W-1:0]          max_audio_step_ms;
        logic [MS_W-1:0]            max_total_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [12:0] extra_video_ms;
        logic [MS_W-1:0]    extra_audio_ms;
        logic signed [12:0] last_video_ms;
        logic signed [1:0]  sync_direction;
    } t_state;

    // halve, rounding toward zero
    function automatic t_wide half_to_zero(input t_wide v);
        t_wide biased;
        biased = v + t_wide'({{(WIDE_W-1){1'b0}}, v[WIDE_W-1]});
        return biased >>> 1;
    endfunction

    function automatic t_wide sext13(input logic [12:0] v);
        return t_wide'({{(WIDE_W-13){v[12]}}, v});
    endfunction

    function automatic t_wide zext12(input logic [MS_W-1:0] v);
        return t_wide'({{(WIDE_W-MS_W){1'b0}}, v});
    endfunction

    function automatic t_wide zext10(input logic [STEP_W-1:0] v);
        return t_wide'({{(WIDE_W-STEP_W){1'b0}}, v});
    endfunction

endpackage

// ===== rtl/core/avls_step.sv =====
// one sync tick: steering decision and next state
module avls_step
    import avls_pkg::*;
(
    input  t_cfg            i_cfg,
    input  t_state          i_state,
    input  logic [MS_W-1:0] i_video_delay_ms,
    input  logic [MS_W-1:0] i_audio_delay_ms,
    input  logic            i_audio_valid,
    output t_state          o_state,
    output logic            o_result,
    output logic [MS_W-1:0] o_audio_extra_delay_ms,
    output logic [MS_W-1:0] o_video_target_ms
);

    t_wide video, audio, offset, vstep, astep, max_total;
    t_wide last_v, extra_v, extra_a;
    t_wide diff, half, step, vd, vd_pos, target;
    t_wide n_extra_v, n_extra_a, n_last_v;
    logic signed [1:0] n_dir;

    assign o_result = i_cfg.sync_enable && i_audio_valid;

    always_comb begin
        video     = zext12(i_video_delay_ms);
        audio     = zext12(i_audio_delay_ms);
        offset    = sext13(i_cfg.network_offset_ms);
        vstep     = zext10(i_cfg.max_video_step_ms);
        astep     = zext10(i_cfg.max_audio_step_ms);
        max_total = zext12(i_cfg.max_total_delay_ms);
        last_v    = sext13(i_state.last_video_ms);
        extra_v   = sext13(i_state.extra_video_ms);
        extra_a   = zext12(i_state.extra_audio_ms);

        diff = video - audio + offset;
        half = half_to_zero(diff);
        step = half;
        vd   = '0;

        n_extra_v = extra_v;
        n_extra_a = extra_a;
        n_last_v  = last_v;
        n_dir     = i_state.sync_direction;

        if (o_result && (audio > AUDIO_FLOOR_MS)) begin
            if (diff > 0) begin
                if (extra_v > 0) begin
                    // back the raised video delay off first
                    vd = video;
                    if (video < last_v - vstep) begin
                        vd        = last_v - vstep;
                        n_extra_v = vd - video;
                    end else begin
                        n_extra_v = '0;
                    end
                    n_last_v  = vd;
                    n_dir     = DIR_VIDEO;
                    n_extra_a = '0;
                end else if (!i_state.sync_direction[1]) begin
                    if (half > astep) begin
                        step = astep;
                    end
                    n_extra_a = extra_a + step;
                    if (n_extra_a > max_total) begin
                        n_extra_a = max_total;
                    end
                    vd        = video;
                    n_extra_v = '0;
                    n_last_v  = video;
                    n_dir     = DIR_AUDIO;
                end else begin
                    // direction flip: settle at neutral for one tick
                    n_extra_a = '0;
                    vd        = video;
                    n_extra_v = '0;
                    n_last_v  = video;
                    n_dir     = DIR_NONE;
                end
            end else begin
                if (extra_a > 0) begin
                    if (half < -astep) begin
                        step = -astep;
                    end
                    n_extra_a = extra_a + step;
                    if (n_extra_a < 0) begin
                        n_extra_a = '0;
                        n_dir     = DIR_NONE;
                    end else begin
                        n_dir = DIR_AUDIO;
                    end
                    vd        = video;
                    n_extra_v = '0;
                    n_last_v  = video;
                end else begin
                    n_extra_a = '0;
                    vd        = video - diff;
                    if (vd > last_v) begin
                        if (vd > last_v + vstep) begin
                            vd = last_v + vstep;
                        end
                        if (vd > max_total) begin
                            vd = max_total;
                        end
                    end else begin
                        if (vd < last_v - vstep) begin
                            vd = last_v - vstep;
                        end
                        if (vd < video) begin
                            vd = video;
                        end
                    end
                    n_extra_v = vd - video;
                    n_last_v  = vd;
                    n_dir     = DIR_VIDEO;
                end
            end
        end

        vd_pos = (vd < 0) ? t_wide'(0) : vd;
        target = (video > vd_pos) ? video : vd_pos;
        if (target > MS_MAX) begin
            target = MS_MAX;
        end
    end

    assign o_state.extra_video_ms = n_extra_v[12:0];
    assign o_state.extra_audio_ms = n_extra_a[MS_W-1:0];
    assign o_state.last_video_ms  = n_last_v[12:0];
    assign o_state.sync_direction = n_dir;

    assign o_audio_extra_delay_ms = n_extra_a[MS_W-1:0];
    assign o_video_target_ms      = target[MS_W-1:0];

endmodule

// ===== rtl/core/av_lip_sync_delay_adjust.sv =====
// lip-sync delay steering: top level with input, state and result registers
//
// Usage: one word on the input channel per sync tick carries the video
// pipeline delay, the audio delay estimate and its valid flag. The block
// answers with one word on the output channel (extra audio delay and video
// minimum playout target), or with none when sync is disabled or the
// estimate is not valid.
// Configuration goes through a separate index/data write channel that is
// always ready; write it only while no tick is in flight.
// Path: each word is held in the input register, and its result is then
// shown from the result register.
// Throughput: one word per cycle unless the receiver stalls; the steering state
// is read and written in the same cycle as the tick, so ticks run back to back.
// Reset clears the steering state, loads the register defaults (sync off,
// zero offset, 80 ms steps, 1500 ms ceiling) and empties both stages.
// When the receiver stalls, the result register holds its word and the
// input register takes one more word before input ready drops.
module av_lip_sync_delay_adjust
    import avls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [MS_W-1:0]      i_video_delay_ms,
    input  logic [MS_W-1:0]      i_audio_delay_ms,
    input  logic                 i_audio_valid,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MS_W-1:0]      o_audio_extra_delay_ms,
    output logic [MS_W-1:0]      o_video_target_ms,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg            r_cfg;
    t_state          r_state;
    t_state          n_state;
    logic            r_in_valid;
    logic [MS_W-1:0] r_video;
    logic [MS_W-1:0] r_audio;
    logic            r_audio_valid;
    logic            r_out_valid;
    logic [MS_W-1:0] r_audio_extra;
    logic [MS_W-1:0] r_target;
    logic            step_result;
    logic [MS_W-1:0] step_audio_extra;
    logic [MS_W-1:0] step_target;
    logic            advance;
    logic            in_take;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    avls_step u_step (
        .i_cfg                  (r_cfg),
        .i_state                (r_state),
        .i_video_delay_ms       (r_video),
        .i_audio_delay_ms       (r_audio),
        .i_audio_valid          (r_audio_valid),
        .o_state                (n_state),
        .o_result               (step_result),
        .o_audio_extra_delay_ms (step_audio_extra),
        .o_video_target_ms      (step_target)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_enable        <= 1'b0;
            r_cfg.network_offset_ms  <= '0;
            r_cfg.max_video_step_ms  <= VIDEO_STEP_RST;
            r_cfg.max_audio_step_ms  <= AUDIO_STEP_RST;
            r_cfg.max_total_delay_ms <= MAX_TOTAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SYNC_ENABLE:    r_cfg.sync_enable        <= i_cfg_data[0];
                CFG_NETWORK_OFFSET: r_cfg.network_offset_ms  <= i_cfg_data[OFFSET_W-1:0];
                CFG_MAX_VIDEO_STEP: r_cfg.max_video_step_ms  <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_AUDIO_STEP: r_cfg.max_audio_step_ms  <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_TOTAL:      r_cfg.max_total_delay_ms <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // a tick without a result frees the result register too
            if (advance) begin
                r_out_valid <= step_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_video       <= i_video_delay_ms;
            r_audio       <= i_audio_delay_ms;
            r_audio_valid <= i_audio_valid;
        end
        if (advance) begin
            r_audio_extra <= step_audio_extra;
            r_target      <= step_target;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_audio_extra_delay_ms = r_audio_extra;
    assign o_video_target_ms      = r_target;

    a_dir_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.sync_direction != 2'sb10)
        else $error("steering direction holds an illegal code");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !advance)
        else $error("tick evaluated while the result register is stalled");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("steering state changed without a tick");

    a_quiet_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !step_result) |=> (!o_out_valid && $stable(r_state)))
        else $error("disabled or invalid tick produced a word or moved the state");

endmodule
